[rtl/led_panel_pixel_remap_macros.svh]
// Assertion macros used by the LED panel pixel remap RTL.
`ifndef LED_PANEL_PIXEL_REMAP_MACROS_SVH
`define LED_PANEL_PIXEL_REMAP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lpr_pkg.sv]
// Types, codes and constants shared by the LED panel pixel remap modules.
`timescale 1ns / 1ps

package lpr_pkg;

   // Field widths of the item ports.
   localparam int PIXEL_W         = 7;
   localparam int OFFSET_W        = 10;
   localparam int POS_W           = OFFSET_W + 1;
   localparam int ORIENT_W        = 2;
   localparam int ORDER_W         = 3;
   localparam int PANEL_CHANNEL_W = 16;
   localparam int SOURCE_W        = 22;
   localparam int SLOT_OFFSET_W   = 2;
   localparam int NUM_SLOTS       = 3;

   // Register file layout.
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 11;
   localparam int PANEL_CFG_W  = 8;
   localparam int MATRIX_CFG_W = 11;

   localparam int PANEL_WIDTH_RESET   = 32;
   localparam int PANEL_HEIGHT_RESET  = 16;
   localparam int MATRIX_WIDTH_RESET  = 32;
   localparam int MATRIX_HEIGHT_RESET = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PANEL_WIDTH   = 3'd0,
      CSR_PANEL_HEIGHT  = 3'd1,
      CSR_MATRIX_WIDTH  = 3'd2,
      CSR_MATRIX_HEIGHT = 3'd3,
      CSR_INVERTED_ROWS = 3'd4
   } csr_index_type;

   typedef enum logic [ORIENT_W-1:0] {
      ORIENT_NORMAL      = 2'd0,
      ORIENT_UPSIDE_DOWN = 2'd1,
      ORIENT_LEFT        = 2'd2,
      ORIENT_RIGHT       = 2'd3
   } orientation_type;

   typedef enum logic [ORDER_W-1:0] {
      ORDER_RGB = 3'd0,
      ORDER_RBG = 3'd1,
      ORDER_GRB = 3'd2,
      ORDER_GBR = 3'd3,
      ORDER_BRG = 3'd4,
      ORDER_BGR = 3'd5
   } color_order_type;

   typedef logic [NUM_SLOTS-1:0][SLOT_OFFSET_W-1:0] slot_offsets_type;

   // Per-item control that travels alongside the pipeline data.
   typedef struct packed {
      logic valid;
      logic out_of_range;
   } stage_ctl_type;

   // Offset of each panel colour slot from the matrix base channel.
   // Unknown orders fall back to RGB.
   function automatic slot_offsets_type slot_offsets(input logic [ORDER_W-1:0] order);
      slot_offsets_type offs;
      case (color_order_type'(order))
         ORDER_RBG: offs = {2'd1, 2'd2, 2'd0};
         ORDER_GRB: offs = {2'd2, 2'd0, 2'd1};
         ORDER_GBR: offs = {2'd0, 2'd2, 2'd1};
         ORDER_BRG: offs = {2'd1, 2'd0, 2'd2};
         ORDER_BGR: offs = {2'd0, 2'd1, 2'd2};
         default:   offs = {2'd2, 2'd1, 2'd0};
      endcase
      return offs;
   endfunction

endpackage

[rtl/led_panel_pixel_remap.sv]
// Top level of the LED panel pixel remap block.
`timescale 1ns / 1ps

// LED panel pixel remap. Each item names one pixel of one panel (column and
// row inside the placed, rotated panel, the panel's offset in the matrix, its
// orientation and its colour order) and yields exactly one result: the
// pixel's first channel inside the panel's own data (three channels a pixel)
// and, for each of the panel's three colour slots, the matrix channel that
// feeds it. Panels turned left or right swap width and height, and matrix
// rows can be counted from the bottom. A pixel outside the panel or the
// configured matrix returns out_of_range set with all channel fields zero.
// Colour orders 6 and 7 behave as RGB. Panel and matrix sizes written above
// MAX_PANEL_DIM or MAX_MATRIX_DIM are clamped to those limits. The block
// takes one item every clock cycle while the output side keeps up. Each item
// passes two stages of adds, compares and operand selection, one stage
// holding the two index multipliers, and the output register with the final
// scaling and colour slot adds. The whole pipeline halts together while a
// finished result waits on rsp_ready, so req_ready follows rsp_ready
// whenever the output register is full. The configuration registers take
// effect on the cycle after the write and are to be changed only while no
// item is in flight.
module led_panel_pixel_remap import lpr_pkg::*; #(
   parameter int MAX_PANEL_DIM  = 128,
   parameter int MAX_MATRIX_DIM = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [PIXEL_W-1:0]         req_pixel_x,
   input  logic [PIXEL_W-1:0]         req_pixel_y,
   input  logic [OFFSET_W-1:0]        req_x_offset,
   input  logic [OFFSET_W-1:0]        req_y_offset,
   input  logic [ORIENT_W-1:0]        req_orientation,
   input  logic [ORDER_W-1:0]         req_color_order,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PANEL_CHANNEL_W-1:0] rsp_panel_channel,
   output logic [SOURCE_W-1:0]        rsp_slot0_source,
   output logic [SOURCE_W-1:0]        rsp_slot1_source,
   output logic [SOURCE_W-1:0]        rsp_slot2_source,
   output logic                       rsp_out_of_range,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   // Widths able to hold a clamped panel or matrix dimension.
   localparam int PANEL_DIM_W  = $clog2(MAX_PANEL_DIM + 1);
   localparam int MATRIX_DIM_W = $clog2(MAX_MATRIX_DIM + 1);

   logic [PANEL_DIM_W-1:0]  panel_width, panel_height;
   logic [MATRIX_DIM_W-1:0] matrix_width, matrix_height;
   logic                    inverted_rows;
   logic                    advance;

   stage_ctl_type           s2_ctl;
   logic [PANEL_DIM_W-1:0]  s2_pa, s2_pb, s2_padd;
   logic [MATRIX_DIM_W-1:0] s2_row, s2_mw, s2_mx;
   logic [ORDER_W-1:0]      s2_order;

   // An item is taken whenever the pipeline moves.
   assign req_ready = advance;

   lpr_csr #(
      .MAX_PANEL_DIM  (MAX_PANEL_DIM),
      .MAX_MATRIX_DIM (MAX_MATRIX_DIM),
      .PANEL_DIM_W    (PANEL_DIM_W),
      .MATRIX_DIM_W   (MATRIX_DIM_W)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .panel_width      (panel_width),
      .panel_height     (panel_height),
      .matrix_width     (matrix_width),
      .matrix_height    (matrix_height),
      .inverted_rows    (inverted_rows)
   );

   lpr_front #(
      .PANEL_DIM_W  (PANEL_DIM_W),
      .MATRIX_DIM_W (MATRIX_DIM_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .req_valid       (req_valid),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_x_offset    (req_x_offset),
      .req_y_offset    (req_y_offset),
      .req_orientation (req_orientation),
      .req_color_order (req_color_order),
      .panel_width     (panel_width),
      .panel_height    (panel_height),
      .matrix_width    (matrix_width),
      .matrix_height   (matrix_height),
      .inverted_rows   (inverted_rows),
      .s2_ctl          (s2_ctl),
      .s2_pa           (s2_pa),
      .s2_pb           (s2_pb),
      .s2_padd         (s2_padd),
      .s2_row          (s2_row),
      .s2_mw           (s2_mw),
      .s2_mx           (s2_mx),
      .s2_order        (s2_order)
   );

   lpr_back #(
      .PANEL_DIM_W  (PANEL_DIM_W),
      .MATRIX_DIM_W (MATRIX_DIM_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .s2_ctl            (s2_ctl),
      .s2_pa             (s2_pa),
      .s2_pb             (s2_pb),
      .s2_padd           (s2_padd),
      .s2_row            (s2_row),
      .s2_mw             (s2_mw),
      .s2_mx             (s2_mx),
      .s2_order          (s2_order),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_panel_channel (rsp_panel_channel),
      .rsp_slot0_source  (rsp_slot0_source),
      .rsp_slot1_source  (rsp_slot1_source),
      .rsp_slot2_source  (rsp_slot2_source),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule

[rtl/lpr_csr.sv]
// Configuration registers, clamped to the supported panel and matrix sizes on write.
`timescale 1ns / 1ps

module lpr_csr import lpr_pkg::*; #(
   parameter int MAX_PANEL_DIM  = 128,
   parameter int MAX_MATRIX_DIM = 1024,
   parameter int PANEL_DIM_W    = 8,
   parameter int MATRIX_DIM_W   = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output logic [PANEL_DIM_W-1:0]  panel_width,
   output logic [PANEL_DIM_W-1:0]  panel_height,
   output logic [MATRIX_DIM_W-1:0] matrix_width,
   output logic [MATRIX_DIM_W-1:0] matrix_height,
   output logic                    inverted_rows
);

   localparam int PSW = (PANEL_DIM_W > PANEL_CFG_W) ? PANEL_DIM_W : PANEL_CFG_W;
   localparam int MSW = (MATRIX_DIM_W > MATRIX_CFG_W) ? MATRIX_DIM_W : MATRIX_CFG_W;

   localparam int PW_RST = (PANEL_WIDTH_RESET > MAX_PANEL_DIM) ?
                           MAX_PANEL_DIM : PANEL_WIDTH_RESET;
   localparam int PH_RST = (PANEL_HEIGHT_RESET > MAX_PANEL_DIM) ?
                           MAX_PANEL_DIM : PANEL_HEIGHT_RESET;
   localparam int MW_RST = (MATRIX_WIDTH_RESET > MAX_MATRIX_DIM) ?
                           MAX_MATRIX_DIM : MATRIX_WIDTH_RESET;
   localparam int MH_RST = (MATRIX_HEIGHT_RESET > MAX_MATRIX_DIM) ?
                           MAX_MATRIX_DIM : MATRIX_HEIGHT_RESET;

   logic [PSW-1:0]          panel_val;
   logic [MSW-1:0]          matrix_val;
   logic [PANEL_DIM_W-1:0]  panel_sat;
   logic [MATRIX_DIM_W-1:0] matrix_sat;

   logic [PANEL_DIM_W-1:0]  panel_width_ff, panel_width_in;
   logic [PANEL_DIM_W-1:0]  panel_height_ff, panel_height_in;
   logic [MATRIX_DIM_W-1:0] matrix_width_ff, matrix_width_in;
   logic [MATRIX_DIM_W-1:0] matrix_height_ff, matrix_height_in;
   logic                    inverted_rows_ff, inverted_rows_in;

   always_comb begin
      panel_val  = PSW'(csr_wdata[PANEL_CFG_W-1:0]);
      matrix_val = MSW'(csr_wdata[MATRIX_CFG_W-1:0]);
      panel_sat  = (panel_val > PSW'(MAX_PANEL_DIM)) ?
                   PANEL_DIM_W'(MAX_PANEL_DIM) : PANEL_DIM_W'(panel_val);
      matrix_sat = (matrix_val > MSW'(MAX_MATRIX_DIM)) ?
                   MATRIX_DIM_W'(MAX_MATRIX_DIM) : MATRIX_DIM_W'(matrix_val);

      panel_width_in   = panel_width_ff;
      panel_height_in  = panel_height_ff;
      matrix_width_in  = matrix_width_ff;
      matrix_height_in = matrix_height_ff;
      inverted_rows_in = inverted_rows_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PANEL_WIDTH:   panel_width_in   = panel_sat;
            CSR_PANEL_HEIGHT:  panel_height_in  = panel_sat;
            CSR_MATRIX_WIDTH:  matrix_width_in  = matrix_sat;
            CSR_MATRIX_HEIGHT: matrix_height_in = matrix_sat;
            CSR_INVERTED_ROWS: inverted_rows_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff   <= PANEL_DIM_W'(PW_RST);
         panel_height_ff  <= PANEL_DIM_W'(PH_RST);
         matrix_width_ff  <= MATRIX_DIM_W'(MW_RST);
         matrix_height_ff <= MATRIX_DIM_W'(MH_RST);
         inverted_rows_ff <= 1'b0;
      end else begin
         panel_width_ff   <= panel_width_in;
         panel_height_ff  <= panel_height_in;
         matrix_width_ff  <= matrix_width_in;
         matrix_height_ff <= matrix_height_in;
         inverted_rows_ff <= inverted_rows_in;
      end
   end

   assign panel_width   = panel_width_ff;
   assign panel_height  = panel_height_ff;
   assign matrix_width  = matrix_width_ff;
   assign matrix_height = matrix_height_ff;
   assign inverted_rows = inverted_rows_ff;

endmodule

[rtl/lpr_front.sv]
// Front pipeline stages: placement sums, range checks and multiplier operand set-up.
`timescale 1ns / 1ps

module lpr_front import lpr_pkg::*; #(
   parameter int PANEL_DIM_W  = 8,
   parameter int MATRIX_DIM_W = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    req_valid,
   input  logic [PIXEL_W-1:0]      req_pixel_x,
   input  logic [PIXEL_W-1:0]      req_pixel_y,
   input  logic [OFFSET_W-1:0]     req_x_offset,
   input  logic [OFFSET_W-1:0]     req_y_offset,
   input  logic [ORIENT_W-1:0]     req_orientation,
   input  logic [ORDER_W-1:0]      req_color_order,
   input  logic [PANEL_DIM_W-1:0]  panel_width,
   input  logic [PANEL_DIM_W-1:0]  panel_height,
   input  logic [MATRIX_DIM_W-1:0] matrix_width,
   input  logic [MATRIX_DIM_W-1:0] matrix_height,
   input  logic                    inverted_rows,
   output stage_ctl_type           s2_ctl,
   output logic [PANEL_DIM_W-1:0]  s2_pa,
   output logic [PANEL_DIM_W-1:0]  s2_pb,
   output logic [PANEL_DIM_W-1:0]  s2_padd,
   output logic [MATRIX_DIM_W-1:0] s2_row,
   output logic [MATRIX_DIM_W-1:0] s2_mw,
   output logic [MATRIX_DIM_W-1:0] s2_mx,
   output logic [ORDER_W-1:0]      s2_order
);

   localparam int PCW = (PANEL_DIM_W > PIXEL_W) ? PANEL_DIM_W : PIXEL_W;
   localparam int MCW = (MATRIX_DIM_W > POS_W) ? MATRIX_DIM_W : POS_W;

   // Stage 1 registers.
   logic                   s1_valid_ff;
   logic [PIXEL_W-1:0]     s1_x_ff, s1_y_ff;
   logic [ORIENT_W-1:0]    s1_orient_ff;
   logic [ORDER_W-1:0]     s1_order_ff;
   logic [PANEL_DIM_W-1:0] s1_pw_ff, s1_ph_ff, s1_pw_in, s1_ph_in;
   logic [POS_W-1:0]       s1_mx_ff, s1_my_ff, s1_mx_in, s1_my_in;
   logic                   rotated;

   // Stage 2 registers.
   stage_ctl_type           s2_ctl_ff, s2_ctl_in;
   logic [PANEL_DIM_W-1:0]  s2_pa_ff, s2_pa_in;
   logic [PANEL_DIM_W-1:0]  s2_pb_ff, s2_pb_in;
   logic [PANEL_DIM_W-1:0]  s2_padd_ff, s2_padd_in;
   logic [MATRIX_DIM_W-1:0] s2_row_ff, s2_row_in;
   logic [MATRIX_DIM_W-1:0] s2_mw_ff;
   logic [MATRIX_DIM_W-1:0] s2_mx_ff;
   logic [ORDER_W-1:0]      s2_order_ff;

   logic [PANEL_DIM_W-1:0]  x_p, y_p, x_rev, y_rev;
   logic [MATRIX_DIM_W-1:0] my_m;

   // Stage 1: rotated panel size and matrix position.
   always_comb begin
      rotated  = (orientation_type'(req_orientation) == ORIENT_LEFT) ||
                 (orientation_type'(req_orientation) == ORIENT_RIGHT);
      s1_pw_in = rotated ? panel_height : panel_width;
      s1_ph_in = rotated ? panel_width : panel_height;
      s1_mx_in = POS_W'(req_x_offset) + POS_W'(req_pixel_x);
      s1_my_in = POS_W'(req_y_offset) + POS_W'(req_pixel_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff      <= req_pixel_x;
         s1_y_ff      <= req_pixel_y;
         s1_orient_ff <= req_orientation;
         s1_order_ff  <= req_color_order;
         s1_pw_ff     <= s1_pw_in;
         s1_ph_ff     <= s1_ph_in;
         s1_mx_ff     <= s1_mx_in;
         s1_my_ff     <= s1_my_in;
      end
   end

   // Stage 2: bounds checks and the operands of both index products.
   // Once the pixel is in range every difference below is non-negative
   // and fits the panel or matrix dimension width.
   always_comb begin
      x_p   = PANEL_DIM_W'(s1_x_ff);
      y_p   = PANEL_DIM_W'(s1_y_ff);
      x_rev = s1_pw_ff - x_p - PANEL_DIM_W'(1);
      y_rev = s1_ph_ff - y_p - PANEL_DIM_W'(1);
      my_m  = MATRIX_DIM_W'(s1_my_ff);

      s2_ctl_in.valid        = s1_valid_ff;
      s2_ctl_in.out_of_range = (PCW'(s1_x_ff) >= PCW'(s1_pw_ff)) ||
                               (PCW'(s1_y_ff) >= PCW'(s1_ph_ff)) ||
                               (MCW'(s1_mx_ff) >= MCW'(matrix_width)) ||
                               (MCW'(s1_my_ff) >= MCW'(matrix_height));

      case (orientation_type'(s1_orient_ff))
         ORIENT_NORMAL: begin
            s2_pa_in   = y_p;
            s2_pb_in   = s1_pw_ff;
            s2_padd_in = x_p;
         end
         ORIENT_UPSIDE_DOWN: begin
            s2_pa_in   = y_rev;
            s2_pb_in   = s1_pw_ff;
            s2_padd_in = x_rev;
         end
         ORIENT_LEFT: begin
            s2_pa_in   = x_p;
            s2_pb_in   = s1_ph_ff;
            s2_padd_in = y_rev;
         end
         default: begin
            s2_pa_in   = x_rev;
            s2_pb_in   = s1_ph_ff;
            s2_padd_in = y_p;
         end
      endcase

      s2_row_in = inverted_rows ? (matrix_height - my_m - MATRIX_DIM_W'(1)) : my_m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (advance) begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_pa_ff    <= s2_pa_in;
         s2_pb_ff    <= s2_pb_in;
         s2_padd_ff  <= s2_padd_in;
         s2_row_ff   <= s2_row_in;
         s2_mw_ff    <= matrix_width;
         s2_mx_ff    <= MATRIX_DIM_W'(s1_mx_ff);
         s2_order_ff <= s1_order_ff;
      end
   end

   assign s2_ctl   = s2_ctl_ff;
   assign s2_pa    = s2_pa_ff;
   assign s2_pb    = s2_pb_ff;
   assign s2_padd  = s2_padd_ff;
   assign s2_row   = s2_row_ff;
   assign s2_mw    = s2_mw_ff;
   assign s2_mx    = s2_mx_ff;
   assign s2_order = s2_order_ff;

endmodule

[rtl/lpr_back.sv]
// Back pipeline stages: index products, channel scaling, colour slots and output register.
`timescale 1ns / 1ps
`include "led_panel_pixel_remap_macros.svh"

module lpr_back import lpr_pkg::*; #(
   parameter int PANEL_DIM_W  = 8,
   parameter int MATRIX_DIM_W = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   output logic                       advance,
   input  stage_ctl_type              s2_ctl,
   input  logic [PANEL_DIM_W-1:0]     s2_pa,
   input  logic [PANEL_DIM_W-1:0]     s2_pb,
   input  logic [PANEL_DIM_W-1:0]     s2_padd,
   input  logic [MATRIX_DIM_W-1:0]    s2_row,
   input  logic [MATRIX_DIM_W-1:0]    s2_mw,
   input  logic [MATRIX_DIM_W-1:0]    s2_mx,
   input  logic [ORDER_W-1:0]         s2_order,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PANEL_CHANNEL_W-1:0] rsp_panel_channel,
   output logic [SOURCE_W-1:0]        rsp_slot0_source,
   output logic [SOURCE_W-1:0]        rsp_slot1_source,
   output logic [SOURCE_W-1:0]        rsp_slot2_source,
   output logic                       rsp_out_of_range
);

   localparam int PPROD_W = 2 * PANEL_DIM_W;
   localparam int MPROD_W = 2 * MATRIX_DIM_W;
   localparam int PCH_W   = (PPROD_W + 3 > PANEL_CHANNEL_W) ? PPROD_W + 3 : PANEL_CHANNEL_W;
   localparam int MCH_W   = (MPROD_W + 3 > SOURCE_W) ? MPROD_W + 3 : SOURCE_W;

   // Stage 3 registers.
   stage_ctl_type           s3_ctl_ff;
   logic [PPROD_W-1:0]      s3_pprod_ff;
   logic [MPROD_W-1:0]      s3_mprod_ff;
   logic [PANEL_DIM_W-1:0]  s3_padd_ff;
   logic [MATRIX_DIM_W-1:0] s3_mx_ff;
   logic [ORDER_W-1:0]      s3_order_ff;

   // Output registers.
   logic                       rsp_valid_ff;
   logic [PANEL_CHANNEL_W-1:0] rsp_panel_channel_ff, rsp_panel_channel_in;
   logic [SOURCE_W-1:0]        rsp_slot0_source_ff, rsp_slot0_source_in;
   logic [SOURCE_W-1:0]        rsp_slot1_source_ff, rsp_slot1_source_in;
   logic [SOURCE_W-1:0]        rsp_slot2_source_ff, rsp_slot2_source_in;
   logic                       rsp_out_of_range_ff;

   logic [PCH_W-1:0]  pidx, pch;
   logic [MCH_W-1:0]  mbase, mch;
   slot_offsets_type  offs;

   // The whole pipeline moves when the output register is free or being emptied.
   assign advance = !rsp_valid_ff || rsp_ready;

   // Stage 3: one multiplier for the panel index and one for the matrix row.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (advance) begin
         s3_ctl_ff <= s2_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_pprod_ff <= PPROD_W'(s2_pa) * PPROD_W'(s2_pb);
         s3_mprod_ff <= MPROD_W'(s2_row) * MPROD_W'(s2_mw);
         s3_padd_ff  <= s2_padd;
         s3_mx_ff    <= s2_mx;
         s3_order_ff <= s2_order;
      end
   end

   // Stage 4: add the column terms, scale by three channels a pixel and
   // spread the matrix base over the colour slots.
   always_comb begin
      pidx  = PCH_W'(s3_pprod_ff) + PCH_W'(s3_padd_ff);
      pch   = (pidx << 1) + pidx;
      mbase = MCH_W'(s3_mprod_ff) + MCH_W'(s3_mx_ff);
      mch   = (mbase << 1) + mbase;
      offs  = slot_offsets(s3_order_ff);

      if (s3_ctl_ff.out_of_range) begin
         rsp_panel_channel_in = '0;
         rsp_slot0_source_in  = '0;
         rsp_slot1_source_in  = '0;
         rsp_slot2_source_in  = '0;
      end else begin
         rsp_panel_channel_in = pch[PANEL_CHANNEL_W-1:0];
         rsp_slot0_source_in  = SOURCE_W'(mch + MCH_W'(offs[0]));
         rsp_slot1_source_in  = SOURCE_W'(mch + MCH_W'(offs[1]));
         rsp_slot2_source_in  = SOURCE_W'(mch + MCH_W'(offs[2]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_panel_channel_ff <= rsp_panel_channel_in;
         rsp_slot0_source_ff  <= rsp_slot0_source_in;
         rsp_slot1_source_ff  <= rsp_slot1_source_in;
         rsp_slot2_source_ff  <= rsp_slot2_source_in;
         rsp_out_of_range_ff  <= s3_ctl_ff.out_of_range;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_panel_channel = rsp_panel_channel_ff;
   assign rsp_slot0_source  = rsp_slot0_source_ff;
   assign rsp_slot1_source  = rsp_slot1_source_ff;
   assign rsp_slot2_source  = rsp_slot2_source_ff;
   assign rsp_out_of_range  = rsp_out_of_range_ff;

   // A flagged item carries no channel numbers.
   `LPR_ASSERT_SAME(a_flagged_zero, clock, reset, rsp_valid_ff && rsp_out_of_range_ff, (rsp_panel_channel_ff == '0) && (rsp_slot0_source_ff == '0) && (rsp_slot1_source_ff == '0) && (rsp_slot2_source_ff == '0), "flagged item has non-zero channels")

   // The three colour slots of a mapped pixel are always distinct channels.
   `LPR_ASSERT_SAME(a_slots_distinct, clock, reset, rsp_valid_ff && !rsp_out_of_range_ff, (rsp_slot0_source_ff != rsp_slot1_source_ff) && (rsp_slot0_source_ff != rsp_slot2_source_ff) && (rsp_slot1_source_ff != rsp_slot2_source_ff), "colour slots share a channel")

   // A stalled pipeline keeps its products and its valid bit.
   `LPR_ASSERT_NEXT(a_stall_holds, clock, reset, !advance, $stable(s3_ctl_ff) && $stable(s3_mprod_ff) && $stable(s3_pprod_ff), "stage 3 changed during a stall")

   // A new result only appears when stage 3 held an item.
   `LPR_ASSERT_SAME(a_valid_source, clock, reset, $rose(rsp_valid_ff), $past(s3_ctl_ff.valid), "result appeared without an item behind it")

endmodule

[tb/led_panel_pixel_remap_test.sv]
// Self-checking testbench for the LED panel pixel remap block.
`timescale 1ns / 1ps

module led_panel_pixel_remap_test;
   import lpr_pkg::*;

   // The block clamps oversized panel and matrix registers to these limits.
   localparam int unsigned PANEL_LIMIT  = 128;
   localparam int unsigned MATRIX_LIMIT = 1024;

   // Idle cycles waited after the last result, so that the pipeline is empty
   // before the registers are touched.
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 20;
   localparam int ITEMS_PER_PHASE = 82;
   localparam int PHASE_COUNT     = 8;
   localparam int HOLD_CYCLES     = 300;
   localparam int REPORT_LIMIT    = 10;
   localparam int TIMEOUT_NS      = 5_000_000;

   // One pixel request as it crosses the input channel.
   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel_x;
      logic [PIXEL_W-1:0]  pixel_y;
      logic [OFFSET_W-1:0] x_offset;
      logic [OFFSET_W-1:0] y_offset;
      orientation_type     orientation;
      logic [ORDER_W-1:0]  color_order;
   } pixel_item_type;

   // One remap result as it leaves on the result channel.
   typedef struct packed {
      logic [PANEL_CHANNEL_W-1:0] panel_channel;
      logic [SOURCE_W-1:0]        slot0_source;
      logic [SOURCE_W-1:0]        slot1_source;
      logic [SOURCE_W-1:0]        slot2_source;
      logic                       out_of_range;
   } remap_result_type;

   // A row of the directed table: the item, and a hand-worked result where
   // it can be read straight off the rules.
   typedef struct {
      pixel_item_type   item;
      bit               has_golden;
      remap_result_type golden;
   } directed_row_type;

   // Every pixel outside the panel or the matrix returns this.
   localparam remap_result_type FLAGGED_RESULT = {16'd0, 22'd0, 22'd0, 22'd0, 1'b1};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [PIXEL_W-1:0]         req_pixel_x      = '0;
   logic [PIXEL_W-1:0]         req_pixel_y      = '0;
   logic [OFFSET_W-1:0]        req_x_offset     = '0;
   logic [OFFSET_W-1:0]        req_y_offset     = '0;
   logic [ORIENT_W-1:0]        req_orientation  = '0;
   logic [ORDER_W-1:0]         req_color_order  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic [PANEL_CHANNEL_W-1:0] rsp_panel_channel;
   logic [SOURCE_W-1:0]        rsp_slot0_source;
   logic [SOURCE_W-1:0]        rsp_slot1_source;
   logic [SOURCE_W-1:0]        rsp_slot2_source;
   logic                       rsp_out_of_range;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index        = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata        = '0;

   // The testbench's own copy of the register file, at the register widths.
   logic [PANEL_CFG_W-1:0]  cfg_panel_width   = PANEL_CFG_W'(PANEL_WIDTH_RESET);
   logic [PANEL_CFG_W-1:0]  cfg_panel_height  = PANEL_CFG_W'(PANEL_HEIGHT_RESET);
   logic [MATRIX_CFG_W-1:0] cfg_matrix_width  = MATRIX_CFG_W'(MATRIX_WIDTH_RESET);
   logic [MATRIX_CFG_W-1:0] cfg_matrix_height = MATRIX_CFG_W'(MATRIX_HEIGHT_RESET);
   logic                    cfg_inverted_rows = 1'b0;

   // Results predicted for accepted items, oldest first.
   remap_result_type expected_results[$];
   directed_row_type directed_rows[$];

   int mismatch_count = 0;

   // Idle percentages for each side; the main process sets them, the
   // drivers only read them.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // A long receiver hold is asked for by bumping stall_requests; the
   // receiver counts the hold out itself.
   int stall_requests = 0;
   int stalls_served  = 0;
   int hold_left      = 0;

   always #5 clock = ~clock;

   led_panel_pixel_remap DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_x_offset      (req_x_offset),
      .req_y_offset      (req_y_offset),
      .req_orientation   (req_orientation),
      .req_color_order   (req_color_order),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_panel_channel (rsp_panel_channel),
      .rsp_slot0_source  (rsp_slot0_source),
      .rsp_slot1_source  (rsp_slot1_source),
      .rsp_slot2_source  (rsp_slot2_source),
      .rsp_out_of_range  (rsp_out_of_range),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   function automatic int unsigned clamp_dim(input int unsigned value,
                                             input int unsigned limit);
      return (value > limit) ? limit : value;
   endfunction

   function automatic bit is_rotated(input orientation_type orient);
      return (orient == ORIENT_LEFT) || (orient == ORIENT_RIGHT);
   endfunction

   // Works out the remap of one pixel under the current register copy.
   function automatic remap_result_type predict_pixel(input pixel_item_type it);
      int unsigned      base_w, base_h, cols, rows, mat_w, mat_h;
      int unsigned      px, py, mx, my, pixel_index, matrix_row, base_channel;
      int unsigned      off0, off1, off2;
      remap_result_type res;
      base_w = clamp_dim(cfg_panel_width, PANEL_LIMIT);
      base_h = clamp_dim(cfg_panel_height, PANEL_LIMIT);
      mat_w  = clamp_dim(cfg_matrix_width, MATRIX_LIMIT);
      mat_h  = clamp_dim(cfg_matrix_height, MATRIX_LIMIT);
      // Turning a panel on its side swaps its width and height.
      cols   = is_rotated(it.orientation) ? base_h : base_w;
      rows   = is_rotated(it.orientation) ? base_w : base_h;
      px     = it.pixel_x;
      py     = it.pixel_y;
      mx     = it.x_offset + px;
      my     = it.y_offset + py;
      if (px >= cols || py >= rows || mx >= mat_w || my >= mat_h) begin
         return FLAGGED_RESULT;
      end
      case (it.orientation)
         ORIENT_NORMAL:      pixel_index = py * cols + px;
         ORIENT_UPSIDE_DOWN: pixel_index = cols * rows - (py * cols + px) - 1;
         ORIENT_LEFT:        pixel_index = px * rows + (rows - py - 1);
         default:            pixel_index = (cols - px - 1) * rows + py;
      endcase
      matrix_row   = cfg_inverted_rows ? (mat_h - my - 1) : my;
      base_channel = (matrix_row * mat_w + mx) * 3;
      // Which matrix colour feeds each panel slot; unknown orders are RGB.
      case (color_order_type'(it.color_order))
         ORDER_RBG: begin off0 = 0; off1 = 2; off2 = 1; end
         ORDER_GRB: begin off0 = 1; off1 = 0; off2 = 2; end
         ORDER_GBR: begin off0 = 1; off1 = 2; off2 = 0; end
         ORDER_BRG: begin off0 = 2; off1 = 0; off2 = 1; end
         ORDER_BGR: begin off0 = 2; off1 = 1; off2 = 0; end
         default:   begin off0 = 0; off1 = 1; off2 = 2; end
      endcase
      res.panel_channel = PANEL_CHANNEL_W'(pixel_index * 3);
      res.slot0_source  = SOURCE_W'(base_channel + off0);
      res.slot1_source  = SOURCE_W'(base_channel + off1);
      res.slot2_source  = SOURCE_W'(base_channel + off2);
      res.out_of_range  = 1'b0;
      return res;
   endfunction

   // Mostly pixels that a panel walker would really send, with random
   // placement; the rest is unconstrained noise or a pixel just past the
   // panel edge.
   function automatic pixel_item_type random_pixel();
      pixel_item_type it;
      int unsigned    cols, rows, mat_w, mat_h, pick;
      pick           = $urandom_range(0, 99);
      it.orientation = orientation_type'($urandom_range(0, 3));
      it.color_order = ORDER_W'($urandom_range(0, 7));
      if (pick < 12) begin
         it.pixel_x  = PIXEL_W'($urandom);
         it.pixel_y  = PIXEL_W'($urandom);
         it.x_offset = OFFSET_W'($urandom);
         it.y_offset = OFFSET_W'($urandom);
         return it;
      end
      cols  = clamp_dim(is_rotated(it.orientation) ? cfg_panel_height : cfg_panel_width,
                        PANEL_LIMIT);
      rows  = clamp_dim(is_rotated(it.orientation) ? cfg_panel_width : cfg_panel_height,
                        PANEL_LIMIT);
      mat_w = clamp_dim(cfg_matrix_width, MATRIX_LIMIT);
      mat_h = clamp_dim(cfg_matrix_height, MATRIX_LIMIT);
      it.pixel_x = (cols == 0) ? '0 : PIXEL_W'($urandom_range(0, cols - 1));
      it.pixel_y = (rows == 0) ? '0 : PIXEL_W'($urandom_range(0, rows - 1));
      // A pixel one step past the panel's right or bottom edge.
      if (pick < 18 && cols < PANEL_LIMIT) it.pixel_x = PIXEL_W'(cols);
      else if (pick < 22 && rows < PANEL_LIMIT) it.pixel_y = PIXEL_W'(rows);
      it.x_offset = (mat_w > it.pixel_x) ?
                    OFFSET_W'($urandom_range(0, mat_w - 1 - it.pixel_x)) : '0;
      it.y_offset = (mat_h > it.pixel_y) ?
                    OFFSET_W'($urandom_range(0, mat_h - 1 - it.pixel_y)) : '0;
      return it;
   endfunction

   task automatic add_row(input int px, input int py, input int xo, input int yo,
                          input orientation_type orient, input int order,
                          input bit has_golden, input remap_result_type golden);
      directed_row_type row_entry;
      row_entry.item.pixel_x     = PIXEL_W'(px);
      row_entry.item.pixel_y     = PIXEL_W'(py);
      row_entry.item.x_offset    = OFFSET_W'(xo);
      row_entry.item.y_offset    = OFFSET_W'(yo);
      row_entry.item.orientation = orient;
      row_entry.item.color_order = ORDER_W'(order);
      row_entry.has_golden       = has_golden;
      row_entry.golden           = golden;
      directed_rows = {directed_rows, row_entry};
   endtask

   // Offers one item, holding it until the block takes it, and records the
   // expected result at the edge of acceptance.
   task automatic offer_item(input pixel_item_type it, input bit has_golden,
                             input remap_result_type golden);
      remap_result_type wanted;
      wanted = has_golden ? golden : predict_pixel(it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_x     <= it.pixel_x;
      req_pixel_y     <= it.pixel_y;
      req_x_offset    <= it.x_offset;
      req_y_offset    <= it.y_offset;
      req_orientation <= it.orientation;
      req_color_order <= it.color_order;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results = {expected_results, wanted};
   endtask

   // Stops offering and waits until every outstanding result is back and
   // the pipeline has had time to empty.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= CSR_DATA_W'(value);
      case (idx)
         CSR_PANEL_WIDTH:   cfg_panel_width   = PANEL_CFG_W'(value);
         CSR_PANEL_HEIGHT:  cfg_panel_height  = PANEL_CFG_W'(value);
         CSR_MATRIX_WIDTH:  cfg_matrix_width  = MATRIX_CFG_W'(value);
         CSR_MATRIX_HEIGHT: cfg_matrix_height = MATRIX_CFG_W'(value);
         default:           cfg_inverted_rows = value[0];
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input int panel_w, input int panel_h,
                                 input int matrix_w, input int matrix_h,
                                 input int inverted);
      write_register(CSR_PANEL_WIDTH, panel_w);
      write_register(CSR_PANEL_HEIGHT, panel_h);
      write_register(CSR_MATRIX_WIDTH, matrix_w);
      write_register(CSR_MATRIX_HEIGHT, matrix_h);
      write_register(CSR_INVERTED_ROWS, inverted);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: checks every accepted result against the oldest
   // expectation, then decides whether to take the next one. All inputs
   // are sampled at the edge, before any of this edge's updates land.
   always @(posedge clock) begin : result_side
      remap_result_type wanted;
      remap_result_type seen;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_panel_channel, rsp_slot0_source, rsp_slot1_source,
                    rsp_slot2_source, rsp_out_of_range};
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Unexpected result at %0t: ch=%0d s0=%0d s1=%0d s2=%0d oor=%0b",
                           $realtime, seen.panel_channel, seen.slot0_source,
                           seen.slot1_source, seen.slot2_source, seen.out_of_range);
               end
            end else begin
               wanted = expected_results.pop_front();
               if (seen.panel_channel !== wanted.panel_channel ||
                   seen.slot0_source  !== wanted.slot0_source  ||
                   seen.slot1_source  !== wanted.slot1_source  ||
                   seen.slot2_source  !== wanted.slot2_source  ||
                   seen.out_of_range  !== wanted.out_of_range) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("Mismatch at %0t: expected ch=%0d s0=%0d s1=%0d s2=%0d oor=%0b",
                              $realtime, wanted.panel_channel, wanted.slot0_source,
                              wanted.slot1_source, wanted.slot2_source,
                              wanted.out_of_range);
                     $display("                 actual ch=%0d s0=%0d s1=%0d s2=%0d oor=%0b",
                              seen.panel_channel, seen.slot0_source, seen.slot1_source,
                              seen.slot2_source, seen.out_of_range);
                  end
               end
            end
         end
         // A requested hold keeps ready low for a long stretch, so that the
         // pipeline fills and back-pressure reaches the input.
         if (stalls_served != stall_requests) begin
            stalls_served = stall_requests;
            hold_left     = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Main sequence: reset, the directed table under the reset settings,
   // then random pixels over a series of register settings.
   initial begin : main_sequence
      int sent;
      int phase;
      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 32 x 16 panel on a 32 x 16 matrix, rows from the top.
      add_row(0, 0, 0, 0, ORIENT_NORMAL, ORDER_RGB, 1, {16'd0, 22'd0, 22'd1, 22'd2, 1'b0});
      add_row(31, 15, 0, 0, ORIENT_NORMAL, ORDER_RGB, 0, '0);
      // Pixels just outside the panel and just outside the matrix.
      add_row(32, 0, 0, 0, ORIENT_NORMAL, ORDER_RGB, 1, FLAGGED_RESULT);
      add_row(0, 16, 0, 0, ORIENT_NORMAL, ORDER_RGB, 1, FLAGGED_RESULT);
      add_row(31, 0, 1, 0, ORIENT_NORMAL, ORDER_RGB, 1, FLAGGED_RESULT);
      add_row(0, 15, 0, 1, ORIENT_NORMAL, ORDER_RGB, 1, FLAGGED_RESULT);
      // Every field at its top value.
      add_row(127, 127, 1023, 1023, ORIENT_RIGHT, 7, 1, FLAGGED_RESULT);
      add_row(0, 0, 0, 0, ORIENT_UPSIDE_DOWN, ORDER_RGB, 0, '0);
      add_row(31, 15, 0, 0, ORIENT_UPSIDE_DOWN, ORDER_BGR, 0, '0);
      add_row(0, 0, 0, 0, ORIENT_LEFT, ORDER_RGB, 0, '0);
      add_row(15, 15, 0, 0, ORIENT_LEFT, ORDER_RBG, 0, '0);
      // A turned panel is only 16 columns wide.
      add_row(16, 0, 0, 0, ORIENT_LEFT, ORDER_RGB, 1, FLAGGED_RESULT);
      add_row(0, 0, 0, 0, ORIENT_RIGHT, ORDER_GRB, 0, '0);
      add_row(15, 15, 16, 0, ORIENT_RIGHT, ORDER_GBR, 0, '0);
      // All eight colour order codes, the two unknown ones included.
      for (int order = 0; order < 8; order++) begin
         add_row(5, 3, 4, 2, ORIENT_NORMAL, order, 0, '0);
      end
      add_row(0, 0, 31, 15, ORIENT_NORMAL, ORDER_BRG, 0, '0);

      // Sender idles lightly, receiver heavily, for the first third.
      send_idle_pct = 19;
      recv_idle_pct = 65;
      foreach (directed_rows[i]) begin
         offer_item(directed_rows[i].item, directed_rows[i].has_golden,
                    directed_rows[i].golden);
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         // The sender pauses here until every result is in.
         wait_drained();
         case (phase)
            0: apply_settings(128, 128, 1024, 1024, 1);
            1: apply_settings(1, 1, 1, 1, 0);
            // Oversized values are clamped to the limits.
            2: apply_settings(255, 200, 2047, 1500, 0);
            // Zero sizes leave every pixel outside.
            3: apply_settings(0, 0, 0, 0, 1);
            4: apply_settings(16, 8, 64, 32, 1);
            5: apply_settings($urandom_range(1, 128), $urandom_range(1, 128),
                              $urandom_range(1, 1024), $urandom_range(1, 1024),
                              $urandom_range(0, 1));
            6: apply_settings(64, 32, 256, 96, 1);
            default: apply_settings(PANEL_WIDTH_RESET, PANEL_HEIGHT_RESET,
                                    MATRIX_WIDTH_RESET, MATRIX_HEIGHT_RESET, 0);
         endcase
         repeat (ITEMS_PER_PHASE) begin
            if (sent == ITEMS_PER_PHASE * PHASE_COUNT / 3) begin
               send_idle_pct = 65;
               recv_idle_pct = 19;
            end
            if (sent == 2 * ITEMS_PER_PHASE * PHASE_COUNT / 3) begin
               // No idling from here on, opened by one long receiver hold
               // while the sender keeps offering.
               send_idle_pct = 0;
               recv_idle_pct = 0;
               stall_requests++;
            end
            offer_item(random_pixel(), 0, '0);
            sent++;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule
